>>> hw/rtl/btrf_pkg.sv
// Shared types, codes and constants for the bit tile rotate and flip block.
`timescale 1ns / 1ps

package btrf_pkg;

  localparam int ROW_W       = 64;  // pixels per stored row word
  localparam int IDX_W       = 6;   // row number width on the ports
  localparam int OPC_W       = 3;   // operation code width
  localparam int TILE_SIDE_D = 64;  // default tile side
  localparam int S_TDATA_W   = 80;  // row_index, row_bits, operation, padded to bytes
  localparam int M_TDATA_W   = 72;  // out_row_index, out_row_bits, padded to bytes

  // Command carried on the slave-side tuser
  localparam logic CMD_LOAD      = 1'b0;
  localparam logic CMD_TRANSFORM = 1'b1;

  // Operation codes; codes above OP_ROT_RIGHT behave as OP_NONE
  localparam logic [OPC_W-1:0] OP_NONE      = 3'd0;
  localparam logic [OPC_W-1:0] OP_MIRROR_H  = 3'd1;
  localparam logic [OPC_W-1:0] OP_MIRROR_V  = 3'd2;
  localparam logic [OPC_W-1:0] OP_ROT_LEFT  = 3'd3;
  localparam logic [OPC_W-1:0] OP_ROT_RIGHT = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BUILD,
    ST_COMMIT,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    TM_HOLD,
    TM_LOAD,
    TM_UP,
    TM_DOWN,
    TM_RIGHT,
    TM_LEFT,
    TM_COMMIT
  } tile_mode_t;

  typedef struct packed {
    tile_mode_t       tile_mode;
    logic [OPC_W-1:0] op;
    logic             scr_push;
    logic             scr_rotate;
    logic             acc_clear;
    logic             emit_load;
    logic             emit_last;
    logic [IDX_W-1:0] emit_idx;
  } ctrl_t;

endpackage

>>> hw/rtl/bit_tile_rotate_flip.sv
// Top level of the bit tile rotate and flip block: ports, output register, checks.
`timescale 1ns / 1ps

// A load beat writes one row of the TILE_SIDE x TILE_SIDE one-bit tile. A
// transform beat runs one shared row-forming unit over the tile, one new row per
// cycle, collecting rows in a scratch ring; a commit state then copies the scratch
// ring back into the tile, and the emit state streams the rows out, pausing while
// the master side stalls. The input is held off from the transform beat until
// the readout ends, and is ready again as soon as the last row sits in the output
// register. The tile resets to all clear; rows narrower than 64 pixels read out
// with zero low bits.
module bit_tile_rotate_flip #(
  parameter int TILE_SIDE = btrf_pkg::TILE_SIDE_D
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // row_index [5:0], row_bits [69:6], operation [72:70], zero [79:73]
  input  logic [btrf_pkg::S_TDATA_W-1:0]  s_tdata,
  // command
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // out_row_index [5:0], out_row_bits [69:6], zero [71:70]
  output logic [btrf_pkg::M_TDATA_W-1:0]  m_tdata,
  // tile_empty
  output logic                            m_tuser,
  output logic                            m_tlast
);

  localparam int STEP_W = $clog2(TILE_SIDE);

  btrf_pkg::ctrl_t                 ctrl;
  logic [btrf_pkg::IDX_W-1:0]      row_index;
  logic [btrf_pkg::ROW_W-1:0]      row_bits;
  logic [btrf_pkg::OPC_W-1:0]      operation;
  logic [TILE_SIDE-1:0]            new_row;
  logic [TILE_SIDE-1:0]            scr_rows [TILE_SIDE];
  logic [TILE_SIDE-1:0]            scr_head;
  logic                            any_set;
  logic                            out_free;
  logic [btrf_pkg::ROW_W-1:0]      out_wide;

  assign row_index = s_tdata[5:0];
  assign row_bits  = s_tdata[69:6];
  assign operation = s_tdata[72:70];
  assign out_free  = !m_tvalid || m_tready;

  // Pixels sit in the top bits of the 64-bit row word
  assign out_wide = btrf_pkg::ROW_W'(scr_head) << (btrf_pkg::ROW_W - TILE_SIDE);

  btrf_seq #(.SIDE(TILE_SIDE)) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .command   (s_tuser),
    .row_index (row_index),
    .operation (operation),
    .out_free  (out_free),
    .in_ready  (s_tready),
    .ctrl      (ctrl)
  );

  btrf_tile #(.SIDE(TILE_SIDE)) u_tile (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .load_idx    (row_index[STEP_W-1:0]),
    .load_row    (row_bits[btrf_pkg::ROW_W-1 -: TILE_SIDE]),
    .commit_rows (scr_rows),
    .new_row     (new_row)
  );

  btrf_scratch #(.SIDE(TILE_SIDE)) u_scratch (
    .clk      (clk),
    .ctrl     (ctrl),
    .new_row  (new_row),
    .rows_out (scr_rows),
    .head     (scr_head),
    .any_set  (any_set)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctrl.emit_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit_load) begin
      m_tdata <= {2'b00, out_wide, ctrl.emit_idx};
      m_tuser <= !any_set;
      m_tlast <= ctrl.emit_last;
    end
  end

  // Readout never overlaps with taking input
  a_emit_not_ready : assert property (@(posedge clk) disable iff (rst)
    ctrl.emit_load |-> !s_tready)
    else $error("row emitted while input is ready");

  // A transform beat holds off the input on the following cycle
  a_transform_busy : assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser == btrf_pkg::CMD_TRANSFORM) |=> !s_tready)
    else $error("input ready straight after a transform beat");

  // Loading the last row ends the readout
  a_last_then_idle : assert property (@(posedge clk) disable iff (rst)
    (ctrl.emit_load && ctrl.emit_last) |=> s_tready)
    else $error("not idle after the last row");

endmodule

>>> hw/rtl/btrf_tile.sv
// Tile store with row and column shift modes, and the shared row-forming unit.
`timescale 1ns / 1ps

module btrf_tile #(
  parameter int SIDE = btrf_pkg::TILE_SIDE_D
) (
  input  logic                  clk,
  input  logic                  rst,
  input  btrf_pkg::ctrl_t       ctrl,
  input  logic [$clog2(SIDE)-1:0] load_idx,
  input  logic [SIDE-1:0]       load_row,
  input  logic [SIDE-1:0]       commit_rows [SIDE],
  output logic [SIDE-1:0]       new_row
);

  logic [SIDE-1:0] rows [SIDE];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SIDE; i++) rows[i] <= '0;
    end else begin
      case (ctrl.tile_mode)
        btrf_pkg::TM_LOAD: begin
          rows[load_idx] <= load_row;
        end
        btrf_pkg::TM_UP: begin
          for (int i = 0; i < SIDE - 1; i++) rows[i] <= rows[i + 1];
          rows[SIDE-1] <= rows[0];
        end
        btrf_pkg::TM_DOWN: begin
          for (int i = 1; i < SIDE; i++) rows[i] <= rows[i - 1];
          rows[0] <= rows[SIDE-1];
        end
        btrf_pkg::TM_RIGHT: begin
          for (int i = 0; i < SIDE; i++) rows[i] <= rows[i] >> 1;
        end
        btrf_pkg::TM_LEFT: begin
          for (int i = 0; i < SIDE; i++) rows[i] <= rows[i] << 1;
        end
        btrf_pkg::TM_COMMIT: begin
          for (int i = 0; i < SIDE; i++) rows[i] <= commit_rows[i];
        end
        default: ;
      endcase
    end
  end

  // One new row per step: read the head row, the tail row or an edge column
  always_comb begin
    new_row = rows[0];
    case (ctrl.op)
      btrf_pkg::OP_MIRROR_H: begin
        for (int x = 0; x < SIDE; x++) new_row[SIDE-1-x] = rows[0][x];
      end
      btrf_pkg::OP_MIRROR_V: begin
        new_row = rows[SIDE-1];
      end
      btrf_pkg::OP_ROT_LEFT: begin
        for (int x = 0; x < SIDE; x++) new_row[SIDE-1-x] = rows[x][0];
      end
      btrf_pkg::OP_ROT_RIGHT: begin
        for (int j = 0; j < SIDE; j++) new_row[j] = rows[j][SIDE-1];
      end
      default: new_row = rows[0];
    endcase
  end

endmodule

>>> hw/rtl/btrf_scratch.sv
// Scratch row ring that collects the transformed tile, with the any-pixel flag.
`timescale 1ns / 1ps

module btrf_scratch #(
  parameter int SIDE = btrf_pkg::TILE_SIDE_D
) (
  input  logic            clk,
  input  btrf_pkg::ctrl_t ctrl,
  input  logic [SIDE-1:0] new_row,
  output logic [SIDE-1:0] rows_out [SIDE],
  output logic [SIDE-1:0] head,
  output logic            any_set
);

  logic [SIDE-1:0] scr [SIDE];
  logic [SIDE-1:0] tail_in;

  assign tail_in = ctrl.scr_push ? new_row : scr[0];

  // Push a new row or recirculate the head; either way the ring advances
  always_ff @(posedge clk) begin
    if (ctrl.scr_push || ctrl.scr_rotate) begin
      for (int i = 0; i < SIDE - 1; i++) scr[i] <= scr[i + 1];
      scr[SIDE-1] <= tail_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.acc_clear) begin
      any_set <= 1'b0;
    end else if (ctrl.scr_push) begin
      any_set <= any_set | (|new_row);
    end
  end

  assign rows_out = scr;
  assign head     = scr[0];

endmodule

>>> hw/rtl/btrf_seq.sv
// Sequencer: accepts items, steps the row unit over the tile, then reads out.
`timescale 1ns / 1ps

module btrf_seq #(
  parameter int SIDE = btrf_pkg::TILE_SIDE_D
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          command,
  input  logic [btrf_pkg::IDX_W-1:0]    row_index,
  input  logic [btrf_pkg::OPC_W-1:0]    operation,
  input  logic                          out_free,
  output logic                          in_ready,
  output btrf_pkg::ctrl_t               ctrl
);

  localparam int STEP_W = $clog2(SIDE);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SIDE - 1);

  btrf_pkg::state_t           state, state_next;
  logic [STEP_W-1:0]          step, step_next;
  logic [btrf_pkg::OPC_W-1:0] op, op_next;
  logic                       accept;
  logic                       row_in_tile;

  assign accept      = in_valid && in_ready;
  assign row_in_tile = ({1'b0, row_index} < (btrf_pkg::IDX_W + 1)'(SIDE));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= btrf_pkg::ST_IDLE;
      step  <= '0;
      op    <= btrf_pkg::OP_NONE;
    end else begin
      state <= state_next;
      step  <= step_next;
      op    <= op_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    op_next    = op;
    case (state)
      btrf_pkg::ST_IDLE: begin
        if (accept && command == btrf_pkg::CMD_TRANSFORM) begin
          state_next = btrf_pkg::ST_BUILD;
          step_next  = '0;
          op_next    = operation;
        end
      end
      btrf_pkg::ST_BUILD: begin
        step_next = step + 1'b1;
        if (step == STEP_LAST) begin
          state_next = btrf_pkg::ST_COMMIT;
          step_next  = '0;
        end
      end
      btrf_pkg::ST_COMMIT: begin
        state_next = btrf_pkg::ST_EMIT;
        step_next  = '0;
      end
      btrf_pkg::ST_EMIT: begin
        if (out_free) begin
          step_next = step + 1'b1;
          if (step == STEP_LAST) begin
            state_next = btrf_pkg::ST_IDLE;
            step_next  = '0;
          end
        end
      end
      default: state_next = btrf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready        = 1'b0;
    ctrl.tile_mode  = btrf_pkg::TM_HOLD;
    ctrl.op         = op;
    ctrl.scr_push   = 1'b0;
    ctrl.scr_rotate = 1'b0;
    ctrl.acc_clear  = 1'b0;
    ctrl.emit_load  = 1'b0;
    ctrl.emit_last  = (step == STEP_LAST);
    ctrl.emit_idx   = btrf_pkg::IDX_W'(step);
    case (state)
      btrf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (accept && command == btrf_pkg::CMD_LOAD && row_in_tile) begin
          ctrl.tile_mode = btrf_pkg::TM_LOAD;
        end
        if (accept && command == btrf_pkg::CMD_TRANSFORM) begin
          ctrl.acc_clear = 1'b1;
        end
      end
      btrf_pkg::ST_BUILD: begin
        ctrl.scr_push = 1'b1;
        case (op)
          btrf_pkg::OP_MIRROR_V:  ctrl.tile_mode = btrf_pkg::TM_DOWN;
          btrf_pkg::OP_ROT_LEFT:  ctrl.tile_mode = btrf_pkg::TM_RIGHT;
          btrf_pkg::OP_ROT_RIGHT: ctrl.tile_mode = btrf_pkg::TM_LEFT;
          default:                ctrl.tile_mode = btrf_pkg::TM_UP;
        endcase
      end
      btrf_pkg::ST_COMMIT: begin
        ctrl.tile_mode = btrf_pkg::TM_COMMIT;
      end
      btrf_pkg::ST_EMIT: begin
        ctrl.emit_load  = out_free;
        ctrl.scr_rotate = out_free;
      end
      default: ;
    endcase
  end

endmodule
